>>> hdl/csc_pkg.sv
// Package for the column-to-span converter: payload structs, memory request
// struct, walker state type and the empty-top constant. No dependencies.
package csc_pkg;

    // One column extent transaction.
    typedef struct packed {
        logic [10:0] column;
        logic [5:0]  top_row;
        logic [5:0]  bottom_row;
        logic        is_empty;
        logic        plane_start;
    } t_col_in;

    // One finished span transaction.
    typedef struct packed {
        logic [5:0] span_row;
        logic [9:0] span_x_start;
        logic [9:0] span_x_end;
        logic       last_span;
    } t_span_out;

    // Start-column memory request. Read and write never share a cycle.
    typedef struct packed {
        logic       rd_en;
        logic       wr_en;
        logic [5:0] row;
        logic [9:0] wr_x;
    } t_mem_req;

    // Walk positions: -1..64 during a walk, or the empty marker.
    typedef logic signed [7:0] t_row_pos;

    // Top of an empty column: lies below every row.
    localparam t_row_pos EMPTY_TOP = 8'sd127;

    typedef enum logic {
        ST_IDLE,
        ST_WALK
    } t_csc_state;

endpackage

>>> hdl/csc_start_mem.sv
// Start-column memory: one entry per row, synchronous read; read data is
// registered and appears the cycle after the read. Rows beyond the depth
// read as zero and ignore writes. Depends on csc_pkg.
module csc_start_mem #(
    parameter int ROWS = 64
) (
    input  logic              i_clk,
    input  csc_pkg::t_mem_req i_req,
    output logic [9:0]        o_rdata
);
    import csc_pkg::*;

    localparam int AW = (ROWS > 1) ? $clog2(ROWS) : 1;

    logic [9:0]    r_mem [ROWS];
    logic [9:0]    r_rdata;
    logic          r_rd_zero;
    logic          in_range;
    logic [AW-1:0] addr;

    assign in_range = (32'(i_req.row) < ROWS);
    assign addr     = AW'(i_req.row);

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en && in_range) begin
            r_mem[addr] <= i_req.wr_x;
        end
    end

    // Read data holds between reads, so a stalled span keeps its start.
    always_ff @(posedge i_clk) begin
        if (i_req.rd_en) begin
            r_rd_zero <= !in_range;
            if (in_range) begin
                r_rdata <= r_mem[addr];
            end
        end
    end

    assign o_rdata = r_rd_zero ? 10'd0 : r_rdata;

endmodule

>>> hdl/csc_walker.sv
// Row walker: keeps the previous extent, steps through closing and opening
// rows one per cycle (closing waits on a stalled span), issues start-memory
// reads and writes, drives spans. Depends on csc_pkg.
module csc_walker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  csc_pkg::t_col_in   i_in,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output csc_pkg::t_span_out o_out,
    output csc_pkg::t_mem_req  o_mem_req,
    input  logic [9:0]         i_start_x
);
    import csc_pkg::*;

    t_csc_state r_state, n_state;
    logic [5:0] r_prev_top, n_prev_top;
    logic [5:0] r_prev_bot, n_prev_bot;
    logic       r_prev_empty, n_prev_empty;
    t_row_pos   r_t1, n_t1, r_b1, n_b1, r_t2, n_t2, r_b2, n_b2;
    logic [9:0] r_x, n_x;
    logic       r_out_valid, n_out_valid;
    logic [5:0] r_out_row, n_out_row;
    logic [9:0] r_out_end, n_out_end;
    logic       r_out_last, n_out_last;

    logic       slot_free;
    logic       close_top, close_bot, open_top, open_bot;
    t_row_pos   t1_inc, b1_dec;

    assign slot_free = !r_out_valid || !i_out_stall;
    assign t1_inc    = r_t1 + 8'sd1;
    assign b1_dec    = r_b1 - 8'sd1;

    assign close_top = (r_t1 < r_t2) && (r_t1 <= r_b1);
    assign close_bot = (r_b1 > r_b2) && (r_b1 >= r_t1);
    assign open_top  = (r_t2 < r_t1) && (r_t2 <= r_b2);
    assign open_bot  = (r_b2 > r_b1) && (r_b2 >= r_t2);

    always_comb begin
        n_state      = r_state;
        n_prev_top   = r_prev_top;
        n_prev_bot   = r_prev_bot;
        n_prev_empty = r_prev_empty;
        n_t1         = r_t1;
        n_b1         = r_b1;
        n_t2         = r_t2;
        n_b2         = r_b2;
        n_x          = r_x;
        n_out_valid  = r_out_valid && i_out_stall;
        n_out_row    = r_out_row;
        n_out_end    = r_out_end;
        n_out_last   = r_out_last;
        o_mem_req    = '0;
        o_in_stall   = (r_state != ST_IDLE);

        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_t1 = (r_prev_empty || i_in.plane_start) ? EMPTY_TOP
                                                              : t_row_pos'({2'b00, r_prev_top});
                    n_b1 = t_row_pos'({2'b00, r_prev_bot});
                    n_t2 = i_in.is_empty ? EMPTY_TOP : t_row_pos'({2'b00, i_in.top_row});
                    n_b2 = t_row_pos'({2'b00, i_in.bottom_row});
                    n_x  = i_in.column[9:0];
                    n_prev_top   = i_in.top_row;
                    n_prev_bot   = i_in.bottom_row;
                    n_prev_empty = i_in.is_empty;
                    n_state      = ST_WALK;
                end
            end
            ST_WALK: begin
                // Phases run in order; each one's condition stays false
                // once it ends, so a priority chain steps them.
                priority if (close_top) begin
                    if (slot_free) begin
                        o_mem_req.rd_en = 1'b1;
                        o_mem_req.row   = r_t1[5:0];
                        n_out_valid     = 1'b1;
                        n_out_row       = r_t1[5:0];
                        n_out_end       = r_x - 10'd1;
                        n_out_last      = !(((t1_inc < r_t2) && (t1_inc <= r_b1))
                                           || ((r_b1 > r_b2) && (r_b1 >= t1_inc)));
                        n_t1            = t1_inc;
                    end
                end else if (close_bot) begin
                    if (slot_free) begin
                        o_mem_req.rd_en = 1'b1;
                        o_mem_req.row   = r_b1[5:0];
                        n_out_valid     = 1'b1;
                        n_out_row       = r_b1[5:0];
                        n_out_end       = r_x - 10'd1;
                        n_out_last      = !((b1_dec > r_b2) && (b1_dec >= r_t1));
                        n_b1            = b1_dec;
                    end
                end else if (open_top) begin
                    o_mem_req.wr_en = 1'b1;
                    o_mem_req.row   = r_t2[5:0];
                    o_mem_req.wr_x  = r_x;
                    n_t2            = r_t2 + 8'sd1;
                end else if (open_bot) begin
                    o_mem_req.wr_en = 1'b1;
                    o_mem_req.row   = r_b2[5:0];
                    o_mem_req.wr_x  = r_x;
                    n_b2            = r_b2 - 8'sd1;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_prev_top   <= 6'd0;
            r_prev_bot   <= 6'd0;
            r_prev_empty <= 1'b1;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_prev_top   <= n_prev_top;
            r_prev_bot   <= n_prev_bot;
            r_prev_empty <= n_prev_empty;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_t1       <= n_t1;
        r_b1       <= n_b1;
        r_t2       <= n_t2;
        r_b2       <= n_b2;
        r_x        <= n_x;
        r_out_row  <= n_out_row;
        r_out_end  <= n_out_end;
        r_out_last <= n_out_last;
    end

    assign o_out_valid        = r_out_valid;
    assign o_out.span_row     = r_out_row;
    assign o_out.span_x_start = i_start_x;
    assign o_out.span_x_end   = r_out_end;
    assign o_out.last_span    = r_out_last;

endmodule

>>> hdl/column_to_span_converter_core.sv
// Column-to-span converter, top level: walker plus start-column memory.
// Depends on csc_pkg, csc_walker and csc_start_mem.
//
// Feed column extents left to right; each column closes the rows its
// predecessor covered that it no longer covers (top rows first, then bottom
// rows) and emits one span transaction per closed row, the last one flagged
// with last_span. Newly covered rows get the current column as their start.
// Set plane_start on the first column of a plane and finish a plane with an
// empty column one past its right edge. An accepted column is first loaded,
// then each row whose coverage changed is handled in turn (one span read or
// one start write each, through the single-port start memory), then the
// walker returns to idle; a column with no change only loads and returns.
// Spans of a column leave at one per cycle while the output is not stalled;
// the output register lets the walker issue the next read while a span is
// still being taken. A span row whose start was never written reports an
// unspecified start column. No clearing pass is needed after reset.
module column_to_span_converter_core #(
    parameter int ROWS = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // column transactions
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  csc_pkg::t_col_in   i_in,
    // span transactions
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output csc_pkg::t_span_out o_out
);
    import csc_pkg::*;

    t_mem_req   mem_req;
    logic [9:0] start_x;

    // Sequencer: owns the previous extent and the span output register.
    csc_walker u_walker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out),
        .o_mem_req   (mem_req),
        .i_start_x   (start_x)
    );

    // Per-row start columns; read data holds while a span is stalled.
    csc_start_mem #(
        .ROWS (ROWS)
    ) u_start_mem (
        .i_clk   (i_clk),
        .i_req   (mem_req),
        .o_rdata (start_x)
    );

endmodule
